// File: design/bmp_pixel_to_rgba_color_key_defines.svh
// Assertion macros shared by the BMP to RGBA converter.
// Expects a clock named clk and an active-low reset named rst_n at the point of use.
`ifndef BMP_PIXEL_TO_RGBA_COLOR_KEY_DEFINES_SVH
`define BMP_PIXEL_TO_RGBA_COLOR_KEY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMPK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMPK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bmpk_pkg.sv
// Types and constants of the BMP pixel to RGBA converter.
// No dependencies; the interfaces, the top level and all submodules but the palette refer to it by scoped names.
package bmpk_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR    = 3'd4;

    localparam logic [1:0] DEPTH_PAL  = 2'd0;
    localparam logic [1:0] DEPTH_BGR  = 2'd1;
    localparam logic [1:0] DEPTH_ABGR = 2'd2;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    localparam int ROW_BYTES_W = 18;

    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  depth_mode;
        logic        key_enable;
        logic [23:0] key_color;
    } cfg_t;

    typedef struct packed {
        logic        is_pal;
        logic        is_32;
        logic [23:0] rgb;
        logic [7:0]  alpha32;
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } meta_t;

    typedef struct packed {
        logic s1_valid;
        logic s1_advance;
    } stage_t;

endpackage

// File: design/bmpk_if.sv
// Handshake channels of the BMP pixel to RGBA converter: input items, RGBA results, config writes.
// Depends on bmpk_pkg for the config port widths.
interface bmpk_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;

    modport source (output valid, operation, data_byte, palette_index, palette_color,
                    input ready);
    modport sink (input valid, operation, data_byte, palette_index, palette_color,
                  output ready);
endinterface

interface bmpk_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic        last_pixel;

    modport source (output valid, red, green, blue, alpha, pixel_x, pixel_y, last_pixel,
                    input ready);
    modport sink (input valid, red, green, blue, alpha, pixel_x, pixel_y, last_pixel,
                  output ready);
endinterface

interface bmpk_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bmpk_pkg::CFG_IDX_W-1:0]  index;
    logic [bmpk_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: design/bmpk_cfg.sv
// Configuration register file of the BMP pixel to RGBA converter.
// Depends on bmpk_pkg for the register indices and the cfg_t bundle.
module bmpk_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [bmpk_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bmpk_pkg::CFG_DATA_W-1:0] wr_data,
    output bmpk_pkg::cfg_t                  cfg
);

    bmpk_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 16'd1;
            cfg_reg.image_height <= 16'd1;
            cfg_reg.depth_mode   <= bmpk_pkg::DEPTH_BGR;
            cfg_reg.key_enable   <= 1'b0;
            cfg_reg.key_color    <= 24'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                bmpk_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width  <= wr_data[15:0];
                bmpk_pkg::REG_IMAGE_HEIGHT: cfg_reg.image_height <= wr_data[15:0];
                bmpk_pkg::REG_DEPTH_MODE:   cfg_reg.depth_mode   <= wr_data[1:0];
                bmpk_pkg::REG_KEY_ENABLE:   cfg_reg.key_enable   <= wr_data[0];
                bmpk_pkg::REG_KEY_COLOR:    cfg_reg.key_color    <= wr_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/bmpk_palette.sv
// 256-entry palette memory with one write port and one registered read port.
// No package dependencies.
module bmpk_palette
(
    input  logic        clk,
    input  logic        wr_en,
    input  logic [7:0]  wr_addr,
    input  logic [23:0] wr_data,
    input  logic        rd_en,
    input  logic [7:0]  rd_addr,
    output logic [23:0] rd_data
);

    logic [23:0] mem [256];
    logic [23:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/bmpk_unpack.sv
// Byte unpacker: drops row padding, assembles pixels and tracks column and row.
// Depends on bmpk_pkg for cfg_t, meta_t and the depth and operation codes.
module bmpk_unpack
(
    input  logic           clk,
    input  logic           rst_n,
    input  bmpk_pkg::cfg_t cfg,
    input  logic           accept,
    input  logic           operation,
    input  logic [7:0]     data_byte,
    output logic           emit,
    output bmpk_pkg::meta_t meta
);

    logic [bmpk_pkg::ROW_BYTES_W-1:0] row_bytes_reg, row_bytes_next;
    logic [15:0] column_reg, column_next;
    logic [15:0] rows_reg, rows_next;
    logic [23:0] assembly_reg, assembly_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;

    logic [15:0] w_eff, h_eff, rows_inc;
    logic [bmpk_pkg::ROW_BYTES_W-1:0] w_ext, data_len, line_len, row_bytes_inc;
    logic [1:0]  last_idx;
    logic        is_pal, is_24, in_data, pixel_op;

    always_comb
    begin
        w_eff  = (cfg.image_width == 16'd0) ? 16'd1 : cfg.image_width;
        h_eff  = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
        w_ext  = {2'b00, w_eff};
        is_pal = (cfg.depth_mode == bmpk_pkg::DEPTH_PAL);
        is_24  = (cfg.depth_mode == bmpk_pkg::DEPTH_BGR);
        priority if (is_pal)
        begin
            data_len = w_ext;
            last_idx = 2'd0;
        end
        else if (is_24)
        begin
            data_len = (w_ext << 1) + w_ext;
            last_idx = 2'd2;
        end
        else
        begin
            data_len = w_ext << 2;
            last_idx = 2'd3;
        end
        line_len      = (data_len + 18'd3) & ~18'd3;
        row_bytes_inc = row_bytes_reg + 18'd1;
        rows_inc      = rows_reg + 16'd1;
        in_data       = (row_bytes_reg < data_len);
        pixel_op      = accept && (operation == bmpk_pkg::OP_PIXEL);

        row_bytes_next = row_bytes_reg;
        column_next    = column_reg;
        rows_next      = rows_reg;
        assembly_next  = assembly_reg;
        byte_idx_next  = byte_idx_reg;
        emit           = 1'b0;

        meta.is_pal  = is_pal;
        meta.is_32   = !is_pal && !is_24;
        meta.rgb     = is_24 ? {data_byte, assembly_reg[15:8], assembly_reg[7:0]}
                             : {data_byte, assembly_reg[23:16], assembly_reg[15:8]};
        meta.alpha32 = assembly_reg[7:0];
        meta.x       = column_reg;
        meta.y       = h_eff - 16'd1 - rows_reg;
        meta.last    = (column_reg == w_eff - 16'd1) && (rows_reg == h_eff - 16'd1);

        if (pixel_op)
        begin
            if (in_data)
            begin
                if (is_pal || byte_idx_reg >= last_idx)
                begin
                    emit          = 1'b1;
                    column_next   = column_reg + 16'd1;
                    assembly_next = is_pal ? assembly_reg : 24'd0;
                    byte_idx_next = is_pal ? byte_idx_reg : 2'd0;
                end
                else
                begin
                    unique case (byte_idx_reg)
                        2'd0: assembly_next[7:0]   = assembly_reg[7:0] | data_byte;
                        2'd1: assembly_next[15:8]  = assembly_reg[15:8] | data_byte;
                        2'd2: assembly_next[23:16] = assembly_reg[23:16] | data_byte;
                        default:
                        begin
                        end
                    endcase
                    byte_idx_next = byte_idx_reg + 2'd1;
                end
            end
            row_bytes_next = row_bytes_inc;
            if (row_bytes_inc >= line_len)
            begin
                row_bytes_next = '0;
                column_next    = 16'd0;
                assembly_next  = 24'd0;
                byte_idx_next  = 2'd0;
                rows_next      = (rows_inc >= h_eff) ? 16'd0 : rows_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= '0;
            column_reg    <= 16'd0;
            rows_reg      <= 16'd0;
            assembly_reg  <= 24'd0;
            byte_idx_reg  <= 2'd0;
        end
        else
        begin
            row_bytes_reg <= row_bytes_next;
            column_reg    <= column_next;
            rows_reg      <= rows_next;
            assembly_reg  <= assembly_next;
            byte_idx_reg  <= byte_idx_next;
        end
    end

endmodule

// File: design/bmpk_out.sv
// Result stage: merges palette read data, applies the colour key and holds the output register.
// Depends on bmpk_pkg for cfg_t, meta_t, stage_t and the alpha constants.
module bmpk_out
(
    input  logic            clk,
    input  logic            rst_n,
    input  bmpk_pkg::cfg_t  cfg,
    input  logic            load,
    input  bmpk_pkg::meta_t meta,
    input  logic [23:0]     pal_data,
    output bmpk_pkg::stage_t status,
    bmpk_out_if.source      rgba
);

    logic            s1_valid_reg;
    bmpk_pkg::meta_t s1_meta_reg;
    logic            out_valid_reg;
    logic [7:0]      red_reg, green_reg, blue_reg, alpha_reg;
    logic [15:0]     x_reg, y_reg;
    logic            last_reg;

    logic        advance;
    logic [23:0] rgb;
    logic [7:0]  alpha;

    always_comb
    begin
        advance = !out_valid_reg || rgba.ready;
        rgb     = s1_meta_reg.is_pal ? pal_data : s1_meta_reg.rgb;
        if (s1_meta_reg.is_32)
        begin
            alpha = s1_meta_reg.alpha32;
        end
        else if (cfg.key_enable && rgb == cfg.key_color)
        begin
            alpha = bmpk_pkg::ALPHA_CLEAR;
        end
        else
        begin
            alpha = bmpk_pkg::ALPHA_OPAQUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_meta_reg <= meta;
        end
        if (advance && s1_valid_reg)
        begin
            red_reg   <= rgb[23:16];
            green_reg <= rgb[15:8];
            blue_reg  <= rgb[7:0];
            alpha_reg <= alpha;
            x_reg     <= s1_meta_reg.x;
            y_reg     <= s1_meta_reg.y;
            last_reg  <= s1_meta_reg.last;
        end
    end

    assign status.s1_valid   = s1_valid_reg;
    assign status.s1_advance = advance;

    assign rgba.valid      = out_valid_reg;
    assign rgba.red        = red_reg;
    assign rgba.green      = green_reg;
    assign rgba.blue       = blue_reg;
    assign rgba.alpha      = alpha_reg;
    assign rgba.pixel_x    = x_reg;
    assign rgba.pixel_y    = y_reg;
    assign rgba.last_pixel = last_reg;

endmodule

// File: design/bmp_pixel_to_rgba_color_key.sv
// Channel   Role    Carries
// cfg       sink    register index and write data, always ready
// pixels    sink    palette writes and pixel-array bytes
// rgba      source  RGBA pixel with column, row and last-pixel flag
// One input transfer per cycle whenever pixels.ready is high.
// The palette memory read and the key compare occupy the middle stage, the output register the last.
// Reset clears the counters and the valid flags at once; the palette holds no reset value.
// A stalled output holds the middle stage, and pixels.ready falls only when both stages are full.
// Depends on bmpk_pkg, bmpk_if.sv, the bmpk_* submodules and the assertion macro header.
`include "bmp_pixel_to_rgba_color_key_defines.svh"

module bmp_pixel_to_rgba_color_key
(
    input  logic        clk,
    input  logic        rst_n,
    bmpk_cfg_if.sink    cfg,
    bmpk_in_if.sink     pixels,
    bmpk_out_if.source  rgba
);

    bmpk_pkg::cfg_t   cfg_regs;
    bmpk_pkg::meta_t  meta;
    bmpk_pkg::stage_t status;
    logic             accept;
    logic             emit;
    logic [23:0]      pal_data;

    assign cfg.ready    = 1'b1;
    assign pixels.ready = !status.s1_valid || status.s1_advance;
    assign accept       = pixels.valid && pixels.ready;

    bmpk_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_regs)
    );

    bmpk_palette u_palette
    (
        .clk     (clk),
        .wr_en   (accept && pixels.operation == bmpk_pkg::OP_PALETTE),
        .wr_addr (pixels.palette_index),
        .wr_data (pixels.palette_color),
        .rd_en   (accept && pixels.operation == bmpk_pkg::OP_PIXEL),
        .rd_addr (pixels.data_byte),
        .rd_data (pal_data)
    );

    bmpk_unpack u_unpack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_regs),
        .accept    (accept),
        .operation (pixels.operation),
        .data_byte (pixels.data_byte),
        .emit      (emit),
        .meta      (meta)
    );

    bmpk_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_regs),
        .load     (emit),
        .meta     (meta),
        .pal_data (pal_data),
        .status   (status),
        .rgba     (rgba)
    );

    `BMPK_ASSERT_SAME(a_no_overrun, status.s1_valid && rgba.valid && !rgba.ready, !pixels.ready, "input taken while both stages are full")
    `BMPK_ASSERT_NEXT(a_palette_silent, accept && pixels.operation == bmpk_pkg::OP_PALETTE, !$rose(status.s1_valid), "palette write produced a pixel")
    `BMPK_ASSERT_SAME(a_last_top_row, rgba.valid && rgba.last_pixel, rgba.pixel_y == 16'd0, "last pixel not on the top row")

endmodule
